/* design/srps_pkg.sv */
// Shared widths, character codes and arithmetic constants for the sensor reply parser.
`timescale 1ns / 1ps
package srps_pkg;

  localparam int MSG_LEN_DEF = 32;

  localparam int FUNC_W   = 1;
  localparam int BYTE_W   = 8;
  localparam int CENTI_W  = 8;
  localparam int PREC_W   = 17;
  localparam int STATUS_W = 1;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int REM_W    = 7;

  localparam logic [FUNC_W-1:0] FUNC_BYTE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_EOM  = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SEP       = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_DOT       = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_M   = 8'h4D;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_N   = 8'h6E;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_M   = 8'h6D;

  localparam logic [GAIN_W-1:0]   GAIN_ONE        = 16'd32768;
  localparam logic [GAIN_W-1:0]   GAIN_LOW_EXCL   = 16'd26214;
  localparam logic [GAIN_W-1:0]   GAIN_HIGH_EXCL  = 16'd39322;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 16'hFFFF;
  localparam logic [PROD_W-1:0]   OVERRANGE_LIMIT = 32'd835584000;
  localparam logic [REM_W:0]      CENTI_DIVISOR   = 8'd100;
  localparam logic [CENTI_W-1:0]  CENTI_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    NM_START = 2'd0,
    NM_M     = 2'd1,
    NM_OK    = 2'd2,
    NM_BAD   = 2'd3
  } name_match_t;

  typedef enum logic [6:0] {
    PH_LEAD_SEP = 7'b0000001,
    PH_NAME     = 7'b0000010,
    PH_MID_SEP  = 7'b0000100,
    PH_INT      = 7'b0001000,
    PH_FRAC     = 7'b0010000,
    PH_DONE     = 7'b0100000,
    PH_REJECT   = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  function automatic logic [13:0] frac_weight(input logic [1:0] idx);
    logic [13:0] w;
    case (idx)
      2'd0: w = 14'd1000;
      2'd1: w = 14'd100;
      2'd2: w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

/* design/srps_byte_if.sv */
// Channel that carries received bytes and end-of-message marks into the parser.
`timescale 1ns / 1ps
interface srps_byte_if;
  logic                         valid;
  logic                         ready;
  logic [srps_pkg::FUNC_W-1:0]  func;
  logic [srps_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

/* design/srps_result_if.sv */
// Channel that carries scaled partial pressure results out of the parser.
`timescale 1ns / 1ps
interface srps_result_if;
  logic                           valid;
  logic                           ready;
  logic [srps_pkg::CENTI_W-1:0]   ppo2_centibar;
  logic [srps_pkg::PREC_W-1:0]    precision_ppo2;
  logic [srps_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output ppo2_centibar, output precision_ppo2, output status,
                  input ready);
  modport sink (input valid, input ppo2_centibar, input precision_ppo2, input status,
                output ready);
endinterface

/* design/sensor_reply_parse_and_scale.sv */
// Oxygen cell reply parser with bit-serial calibration multiply and divide-by-100.
// Flow: a byte transaction is absorbed when it is taken; a valid end of message starts a
// scaling pass (16 multiply steps, 17 divide steps), then the result is loaded once the output is free.
// Throughput: one byte per cycle while idle; no input is taken during the scaling pass or while
// its result waits to load; the pass is made by the shift-add multiplier and the restoring divider.
// Reset: rst clears the parse state, empties the output register and sets the gain to 1.0.
`timescale 1ns / 1ps
module sensor_reply_parse_and_scale #(
  parameter int MSG_LEN = srps_pkg::MSG_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  srps_byte_if.sink                     msg,
  srps_result_if.source                 result,
  input  logic                          cfg_we,
  input  logic [srps_pkg::GAIN_W-1:0]   cfg_wdata
);
  import srps_pkg::*;

  localparam int CNT_W     = $clog2(MSG_LEN);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MSG_LEN - 1);
  localparam int MUL_STEPS = SAMPLE_W;
  localparam int DIV_STEPS = PREC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  logic [GAIN_W-1:0]   cal_coefficient;
  logic [CNT_W-1:0]    char_count, char_count_next;
  logic [CNT_W-1:0]    skip_count, skip_count_next;
  logic                leading_phase, leading_phase_next;
  logic                line_done, line_done_next;
  phase_t              token_phase, token_phase_next;
  name_match_t         name_match, name_match_next;
  logic [SAMPLE_W-1:0] sample_value, sample_value_next;
  logic [2:0]          fraction_digits, fraction_digits_next;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] mcand;
  logic [PROD_W-1:0]   prod, prod_next;
  logic [PREC_W-1:0]   quo;
  logic [REM_W-1:0]    rem;
  logic                over;

  logic                result_valid;
  logic                result_load;
  logic [CENTI_W-1:0]  centi_out;
  logic [PREC_W-1:0]   prec_out;
  logic                status_out;

  logic                msg_accept, res_accept, start_scale, int_char;
  logic [BYTE_W-1:0]   b;
  logic                is_digit, is_null_lf;
  logic [3:0]          d;
  logic [19:0]         int_sum;
  logic [16:0]         frac_sum;
  logic [SAMPLE_W:0]   mul_sum;
  logic [REM_W:0]      div_shift, div_diff;
  logic                div_ge;
  logic [GAIN_W-1:0]   gain_sel;

  assign msg.ready      = (state == ST_IDLE);
  assign msg_accept     = msg.valid && msg.ready;
  assign res_accept     = result_valid && result.ready;
  assign result_load    = (state == ST_FIN) && (!result_valid || result.ready);
  assign result.valid          = result_valid;
  assign result.ppo2_centibar  = centi_out;
  assign result.precision_ppo2 = prec_out;
  assign result.status         = status_out;

  assign b          = msg.rx_byte;
  assign is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign d          = is_digit ? b[3:0] : 4'd0;
  assign is_null_lf = (b == CHAR_NUL) || (b == CHAR_LF);
  assign int_sum    = ({4'd0, sample_value} << 3) + ({4'd0, sample_value} << 1)
                      + (20'(d) * 20'd10000);
  assign frac_sum   = 17'(sample_value)
                      + 17'(18'(d) * 18'(frac_weight(fraction_digits[1:0])));
  assign gain_sel   = ((cal_coefficient > GAIN_LOW_EXCL) && (cal_coefficient < GAIN_HIGH_EXCL))
                      ? cal_coefficient : GAIN_ONE;

  assign mul_sum    = {1'b0, prod[PROD_W-1:SAMPLE_W]} + (prod[0] ? {1'b0, mcand} : '0);
  assign prod_next  = {mul_sum, prod[SAMPLE_W-1:1]};
  assign div_shift  = {rem, quo[PREC_W-1]};
  assign div_ge     = (div_shift >= CENTI_DIVISOR);
  assign div_diff   = div_shift - CENTI_DIVISOR;

  function automatic name_match_t name_step(input name_match_t nm, input logic [BYTE_W-1:0] c);
    name_match_t r;
    case (nm)
      NM_START: r = (c == CHAR_UPPER_M) ? NM_M : NM_BAD;
      NM_M:     r = ((c == CHAR_LOWER_N) || (c == CHAR_LOWER_M)) ? NM_OK : NM_BAD;
      default:  r = NM_BAD;
    endcase
    return r;
  endfunction

  always_comb begin
    char_count_next      = char_count;
    skip_count_next      = skip_count;
    leading_phase_next   = leading_phase;
    line_done_next       = line_done;
    token_phase_next     = token_phase;
    name_match_next      = name_match;
    sample_value_next    = sample_value;
    fraction_digits_next = fraction_digits;
    start_scale          = 1'b0;
    int_char             = 1'b0;
    if (msg_accept) begin
      if (msg.func == FUNC_EOM) begin
        start_scale = (token_phase == PH_INT) || (token_phase == PH_FRAC)
                      || (token_phase == PH_DONE);
        char_count_next      = '0;
        skip_count_next      = '0;
        leading_phase_next   = 1'b1;
        line_done_next       = 1'b0;
        token_phase_next     = PH_LEAD_SEP;
        name_match_next      = NM_START;
        sample_value_next    = '0;
        fraction_digits_next = '0;
      end else if (!line_done) begin
        if (leading_phase && is_null_lf && (skip_count < CNT_MAX)) begin
          skip_count_next = skip_count + 1'b1;
        end else begin
          leading_phase_next = 1'b0;
          if (is_null_lf || (b == CHAR_CR) || (char_count >= CNT_MAX)) begin
            line_done_next = 1'b1;
          end else begin
            char_count_next = char_count + 1'b1;
            if (char_count_next >= CNT_MAX) begin
              line_done_next = 1'b1;
            end
            case (token_phase)
              PH_LEAD_SEP: begin
                if (b != CHAR_SEP) begin
                  token_phase_next = PH_NAME;
                  name_match_next  = name_step(name_match, b);
                end
              end
              PH_NAME: begin
                if (b == CHAR_SEP) begin
                  token_phase_next = (name_match == NM_OK) ? PH_MID_SEP : PH_REJECT;
                end else begin
                  name_match_next = name_step(name_match, b);
                end
              end
              PH_MID_SEP: begin
                if (b != CHAR_SEP) begin
                  int_char = 1'b1;
                end
              end
              PH_INT: begin
                int_char = 1'b1;
              end
              PH_FRAC: begin
                if (is_digit) begin
                  if (fraction_digits < 3'd4) begin
                    sample_value_next    = (frac_sum > 17'(SAMPLE_MAX)) ? SAMPLE_MAX
                                           : frac_sum[SAMPLE_W-1:0];
                    fraction_digits_next = fraction_digits + 1'b1;
                  end
                end else begin
                  token_phase_next = PH_DONE;
                end
              end
              default: begin
              end
            endcase
            if (int_char) begin
              if (is_digit) begin
                token_phase_next  = PH_INT;
                sample_value_next = (int_sum > 20'(SAMPLE_MAX)) ? SAMPLE_MAX
                                    : int_sum[SAMPLE_W-1:0];
              end else if (b == CHAR_DOT) begin
                token_phase_next = PH_FRAC;
              end else begin
                token_phase_next = PH_DONE;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_coefficient <= GAIN_ONE;
      char_count      <= '0;
      skip_count      <= '0;
      leading_phase   <= 1'b1;
      line_done       <= 1'b0;
      token_phase     <= PH_LEAD_SEP;
      name_match      <= NM_START;
      sample_value    <= '0;
      fraction_digits <= '0;
      state           <= ST_IDLE;
      step            <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cal_coefficient <= cfg_wdata;
      end
      char_count      <= char_count_next;
      skip_count      <= skip_count_next;
      leading_phase   <= leading_phase_next;
      line_done       <= line_done_next;
      token_phase     <= token_phase_next;
      name_match      <= name_match_next;
      sample_value    <= sample_value_next;
      fraction_digits <= fraction_digits_next;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (res_accept) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start_scale) begin
            state <= ST_MUL;
            step  <= '0;
          end
        end
        ST_MUL: begin
          if (step == MUL_LAST) begin
            state <= ST_DIV;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (result_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start_scale) begin
          mcand <= sample_value;
          prod  <= {{(PROD_W-GAIN_W){1'b0}}, gain_sel};
        end
      end
      ST_MUL: begin
        prod <= prod_next;
        if (step == MUL_LAST) begin
          over <= (prod_next > OVERRANGE_LIMIT);
          quo  <= prod_next[PROD_W-1:PROD_W-PREC_W];
          rem  <= '0;
        end
      end
      ST_DIV: begin
        rem <= div_ge ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
        quo <= {quo[PREC_W-2:0], div_ge};
      end
      ST_FIN: begin
        if (result_load) begin
          centi_out  <= (quo > PREC_W'(CENTI_MAX)) ? CENTI_MAX : quo[CENTI_W-1:0];
          prec_out   <= prod[PROD_W-1:PROD_W-PREC_W];
          status_out <= over;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_status_saturates: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status) |-> (result.ppo2_centibar == CENTI_MAX))
    else $error("overrange result without saturated centibar value");

  a_centi_consistent: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.status)
      |-> ((17'(result.ppo2_centibar) * 17'd100) <= result.precision_ppo2))
    else $error("centibar value exceeds precision value");

  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    (msg_accept && (msg.func == FUNC_EOM))
      |=> (leading_phase && (char_count == '0) && (token_phase == PH_LEAD_SEP)))
    else $error("line state not cleared after end of message");

  a_skip_before_chars: assert property (@(posedge clk) disable iff (rst)
    leading_phase |-> (char_count == '0))
    else $error("bytes kept while still skipping leading junk");

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MUL) && (step == MUL_LAST)) |=> (state == ST_DIV))
    else $error("multiply pass did not hand over to divide");
`endif

endmodule
